>>> src/rcf_pkg.sv
// Shared types, constants and register indexes of the RTMP chunk framer.
package rcf_pkg;

  localparam int COUNT_W     = 24;
  localparam int CSID_W      = 6;
  localparam int CS_W        = 16;
  localparam int CS_EFF_W    = CS_W + 1;
  localparam int MSID_W      = 32;
  localparam int HDR_BYTES   = 12;
  localparam int ITEM_BYTES  = HDR_BYTES + 1;
  localparam int IDX_W       = $clog2(ITEM_BYTES);
  localparam int STEP_W      = $clog2(COUNT_W);
  localparam int CFG_W       = 32;
  localparam int CFG_IDX_W   = 1;

  localparam logic [7:0]      TYPE3_MARK       = 8'hC0;
  localparam logic [CS_W-1:0] CHUNK_SIZE_RESET = 16'd128;

  localparam logic [CFG_IDX_W-1:0] CFG_MSG_STREAM_ID = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_SIZE    = 1'd1;

  // One framed input: up to a full type-0 header plus one payload byte.
  typedef struct packed {
    logic [ITEM_BYTES-1:0][7:0] bytes;
    logic [IDX_W-1:0]           last_idx;
  } rcf_item_t;

  // Per-message framing state. rem is the payload count modulo chunk size.
  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [CS_W-1:0]    rem;
    logic [CSID_W-1:0]  csid;
  } rcf_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } rcf_rem_stat_t;

  typedef enum logic {
    REM_IDLE,
    REM_RUN
  } rcf_rem_state_t;

endpackage

>>> src/rcf_frame_build.sv
// Combinational framing of one input transaction into its result bytes.
module rcf_frame_build import rcf_pkg::*; (
  input  logic [7:0]          data_byte,
  input  logic                first,
  input  logic [CSID_W-1:0]   chunk_stream_id,
  input  logic [COUNT_W-1:0]  message_timestamp,
  input  logic [COUNT_W-1:0]  message_length,
  input  logic [7:0]          message_type,
  input  logic [MSID_W-1:0]   msid,
  input  logic [CS_EFF_W-1:0] cs_eff,
  input  rcf_state_t          st,
  output rcf_item_t           item,
  output rcf_state_t          st_nxt
);

  logic [COUNT_W-1:0]  cnt_inc;
  logic [CS_EFF_W-1:0] rem_inc;
  logic                opens;

  assign cnt_inc = st.count + COUNT_W'(1);
  assign rem_inc = {1'b0, st.rem} + CS_EFF_W'(1);
  assign opens   = (st.count != '0) && (st.rem == '0);

  always_comb begin
    item   = '0;
    st_nxt = st;
    if (first) begin
      item.bytes[0]  = {2'b00, chunk_stream_id};
      item.bytes[1]  = message_timestamp[23:16];
      item.bytes[2]  = message_timestamp[15:8];
      item.bytes[3]  = message_timestamp[7:0];
      item.bytes[4]  = message_length[23:16];
      item.bytes[5]  = message_length[15:8];
      item.bytes[6]  = message_length[7:0];
      item.bytes[7]  = message_type;
      item.bytes[8]  = msid[7:0];
      item.bytes[9]  = msid[15:8];
      item.bytes[10] = msid[23:16];
      item.bytes[11] = msid[31:24];
      item.bytes[12] = data_byte;
      st_nxt.csid    = chunk_stream_id;
      if (message_length != '0) begin
        item.last_idx = IDX_W'(HDR_BYTES);
        st_nxt.count  = COUNT_W'(1);
        st_nxt.rem    = (cs_eff == CS_EFF_W'(1)) ? '0 : CS_W'(1);
      end else begin
        item.last_idx = IDX_W'(HDR_BYTES - 1);
        st_nxt.count  = '0;
        st_nxt.rem    = '0;
      end
    end else begin
      if (opens) begin
        item.bytes[0] = TYPE3_MARK | {2'b00, st.csid};
        item.bytes[1] = data_byte;
        item.last_idx = IDX_W'(1);
      end else begin
        item.bytes[0] = data_byte;
        item.last_idx = '0;
      end
      st_nxt.count = cnt_inc;
      // A count that wraps to zero starts the modulo over as well.
      if ((cnt_inc == '0) || (rem_inc == cs_eff)) begin
        st_nxt.rem = '0;
      end else begin
        st_nxt.rem = rem_inc[CS_W-1:0];
      end
    end
  end

endmodule

>>> src/rcf_rem_unit.sv
// Bit-serial remainder of the payload count by a newly written chunk size.
module rcf_rem_unit import rcf_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [COUNT_W-1:0]  count,
  input  logic [CS_EFF_W-1:0] cs_eff,
  output rcf_rem_stat_t       stat,
  output logic [CS_W-1:0]     rem
);

  rcf_rem_state_t      state_r, state_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic [COUNT_W-1:0]  sh_r, sh_nxt;
  logic [CS_EFF_W-1:0] acc_r, acc_nxt;
  logic [CS_EFF_W-1:0] trial;
  logic [CS_EFF_W-1:0] red;

  // Partial remainder stays below the divisor, so its top bit is always clear.
  assign trial = {acc_r[CS_EFF_W-2:0], sh_r[COUNT_W-1]};
  assign red   = (trial >= cs_eff) ? (trial - cs_eff) : trial;
  assign rem   = red[CS_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= REM_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
    sh_r  <= sh_nxt;
    acc_r <= acc_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    sh_nxt    = sh_r;
    acc_nxt   = acc_r;
    stat      = '0;
    case (state_r)
      REM_IDLE: begin
        if (start) begin
          state_nxt = REM_RUN;
          step_nxt  = '0;
          sh_nxt    = count;
          acc_nxt   = '0;
        end
      end
      REM_RUN: begin
        stat.busy = 1'b1;
        acc_nxt   = red;
        sh_nxt    = {sh_r[COUNT_W-2:0], 1'b0};
        step_nxt  = step_r + STEP_W'(1);
        if (step_r == STEP_W'(COUNT_W - 1)) begin
          stat.done = 1'b1;
          state_nxt = REM_IDLE;
        end
      end
      default: begin
        state_nxt = REM_IDLE;
      end
    endcase
  end

endmodule

>>> src/rcf_out_stage.sv
// Item register and byte serializer feeding the registered result channel.
module rcf_out_stage import rcf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      load,
  input  rcf_item_t item,
  output logic      ready,
  output logic      out_valid,
  input  logic      out_stall,
  output logic [7:0] out_byte,
  output logic      out_last
);

  logic             a_valid_r;
  rcf_item_t        item_r;
  logic [IDX_W-1:0] idx_r;
  logic             ov_r;
  logic [7:0]       ob_r;
  logic             ol_r;
  logic             move;
  logic             fin;

  assign move  = a_valid_r && (!ov_r || !out_stall);
  assign fin   = move && (idx_r == item_r.last_idx);
  assign ready = !a_valid_r || fin;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      ov_r      <= 1'b0;
      idx_r     <= '0;
    end else begin
      if (load) begin
        a_valid_r <= 1'b1;
        idx_r     <= '0;
      end else begin
        if (fin) begin
          a_valid_r <= 1'b0;
        end
        if (move) begin
          idx_r <= idx_r + IDX_W'(1);
        end
      end
      if (move) begin
        ov_r <= 1'b1;
      end else if (!out_stall) begin
        ov_r <= 1'b0;
      end
    end
    if (load) begin
      item_r <= item;
    end
    if (move) begin
      ob_r <= item_r.bytes[idx_r];
      ol_r <= (idx_r == item_r.last_idx);
    end
  end

  assign out_valid = ov_r;
  assign out_byte  = ob_r;
  assign out_last  = ol_r;

endmodule

>>> src/rtmp_chunk_framer_core.sv
// Top level of the RTMP chunk framer: configuration, framing state and datapath.
//
// Payload bytes of a message enter one per input transaction and leave as an RTMP
// chunk stream, one byte per result transaction, with out_last marking the final
// byte that an input transaction causes. A transaction with first set emits a
// 12-byte type-0 header (12 bytes only if its length is zero, else 13 with the
// payload byte); a payload byte that opens a new chunk emits a one-byte type-3
// header ahead of it (2 bytes); any other payload byte emits itself alone. Each
// transaction is framed combinationally into an item register, and a serializer
// drains it into the output register at one byte per cycle while out_stall is
// low, so the block then takes one input transaction per cycle for plain payload
// bytes; a transaction that emits more bytes holds input off until the serializer
// has moved its last byte out. A write to chunk_size starts a bit-serial remainder
// pass that aligns the chunk position of the current message to the new size;
// input is stalled from that write until the pass is done. The timestamp is 24
// bits and no extended timestamp is ever sent. A chunk_size of zero means 65536.
module rtmp_chunk_framer_core import rcf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  // Input channel.
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_data_byte,
  input  logic                 in_first,
  input  logic [CSID_W-1:0]    in_chunk_stream_id,
  input  logic [COUNT_W-1:0]   in_message_timestamp,
  input  logic [COUNT_W-1:0]   in_message_length,
  input  logic [7:0]           in_message_type,
  // Result channel.
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           out_byte,
  output logic                 out_last,
  // Configuration write port.
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  logic [MSID_W-1:0]   msid_r;
  logic [CS_W-1:0]     cs_r;
  logic                cs_pend_r;
  rcf_state_t          st_r;
  rcf_state_t          st_nxt;
  rcf_item_t           item;
  logic [CS_EFF_W-1:0] cs_eff;
  logic                accept;
  logic                os_ready;
  rcf_rem_stat_t       rem_stat;
  logic [CS_W-1:0]     rem_res;

  // Zero in the 16-bit register stands for a 65536-byte chunk.
  assign cs_eff = {(cs_r == '0), cs_r};

  // Input is held off while a configuration write lands and while the chunk
  // position is being recomputed, so no transaction sees a stale remainder.
  assign in_stall = !os_ready || cfg_we || cs_pend_r || rem_stat.busy;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      msid_r    <= '0;
      cs_r      <= CHUNK_SIZE_RESET;
      cs_pend_r <= 1'b0;
      st_r      <= '0;
    end else begin
      cs_pend_r <= cfg_we && (cfg_index == CFG_CHUNK_SIZE);
      if (cfg_we) begin
        case (cfg_index)
          CFG_MSG_STREAM_ID: msid_r <= cfg_wdata[MSID_W-1:0];
          CFG_CHUNK_SIZE:    cs_r   <= cfg_wdata[CS_W-1:0];
          default: begin
          end
        endcase
      end
      if (accept) begin
        st_r <= st_nxt;
      end else if (rem_stat.done) begin
        st_r.rem <= rem_res;
      end
    end
  end

  rcf_frame_build u_build (
    .data_byte         (in_data_byte),
    .first             (in_first),
    .chunk_stream_id   (in_chunk_stream_id),
    .message_timestamp (in_message_timestamp),
    .message_length    (in_message_length),
    .message_type      (in_message_type),
    .msid              (msid_r),
    .cs_eff            (cs_eff),
    .st                (st_r),
    .item              (item),
    .st_nxt            (st_nxt)
  );

  rcf_rem_unit u_rem (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cs_pend_r),
    .count  (st_r.count),
    .cs_eff (cs_eff),
    .stat   (rem_stat),
    .rem    (rem_res)
  );

  rcf_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (accept),
    .item      (item),
    .ready     (os_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

endmodule

>>> src/rcf_checker.sv
// Port-level checker for the RTMP chunk framer, bound to the top level.
module rcf_checker import rcf_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic [7:0]           out_byte,
  input logic                 out_last,
  input logic                 cfg_we,
  input logic [CFG_IDX_W-1:0] cfg_index
);

  // A stalled result transaction keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(out_last))
    else $error("result changed while stalled");

  // No input transaction completes in the cycle of a configuration write.
  a_cfg_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |-> !(in_valid && !in_stall))
    else $error("input accepted during configuration write");

  // A chunk size write holds input off while it is pending and as the chunk position realignment begins.
  a_cs_realign: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we && (cfg_index == CFG_CHUNK_SIZE) |=> in_stall ##1 in_stall)
    else $error("input accepted before chunk position realigned");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind rtmp_chunk_framer_core rcf_checker u_rcf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_byte  (out_byte),
  .out_last  (out_last),
  .cfg_we    (cfg_we),
  .cfg_index (cfg_index)
);
